// File: rtl/tcasd_pkg.sv
// ----------------------------------------------------------------------------
// tcasd_pkg - shared types and constants of the angle sensor decoder
// Word formats between the pipeline stages, register indexes and the CORDIC
// angle table in 2^-32 turn units.
// ----------------------------------------------------------------------------
package tcasd_pkg;

   // sample and register width
   localparam int SAMPLE_BITS = 12;
   // configuration index width and register indexes
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_A_MAX = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_A_MIN = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_MAX = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_MIN = 8'd3;

   // register reset values
   localparam logic [SAMPLE_BITS-1:0] RST_CH_MAX = 12'd2600;
   localparam logic [SAMPLE_BITS-1:0] RST_CH_MIN = 12'd1280;

   // signed offset and amplitude, and their product
   localparam int OFS_W  = SAMPLE_BITS + 1;
   localparam int PROD_W = 2 * OFS_W;
   // scaled CORDIC vector: product, 24 fraction bits, growth headroom
   localparam int FRAC_BITS = 24;
   localparam int VEC_W     = PROD_W + FRAC_BITS + 1;
   // turn fraction accumulator
   localparam int TURN_W    = 32;
   localparam int QUAD_BITS = 30;
   localparam int TAB_LEN   = 24;

   // output scaling
   localparam int ANGLE_W = 10;
   localparam int STEPS_W = 10;
   localparam logic [STEPS_W-1:0] ANGLE_STEPS = 10'd1000;

   // atan(2^-i) in 2^-32 turn units
   localparam logic signed [TURN_W-1:0] ATAN_TAB [TAB_LEN] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] a_max;
      logic [SAMPLE_BITS-1:0] a_min;
      logic [SAMPLE_BITS-1:0] b_max;
      logic [SAMPLE_BITS-1:0] b_min;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] a_sample;
      logic [SAMPLE_BITS-1:0] b_sample;
   } sample_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] x;
      logic signed [PROD_W-1:0] y;
      logic                     invalid;
   } prod_type;

   typedef struct packed {
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [TURN_W-1:0] z;
      logic [1:0]               q;
      logic                     invalid;
   } vec_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               invalid;
   } result_type;

endpackage

// File: rtl/tcasd_ifs.sv
// ----------------------------------------------------------------------------
// tcasd_ifs - channel interfaces of the angle sensor decoder
// Sample pair channel, angle result channel and register write channel.
// ----------------------------------------------------------------------------
interface tcasd_req_if;
   logic                             valid;
   logic                             ready;
   logic [tcasd_pkg::SAMPLE_BITS-1:0] a_sample;
   logic [tcasd_pkg::SAMPLE_BITS-1:0] b_sample;

   modport source (output valid, output a_sample, output b_sample, input ready);
   modport sink   (input valid, input a_sample, input b_sample, output ready);
endinterface

interface tcasd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcasd_pkg::ANGLE_W-1:0] angle_milliturn;
   logic                         angle_invalid;

   modport source (output valid, output angle_milliturn, output angle_invalid,
                   input ready);
   modport sink   (input valid, input angle_milliturn, input angle_invalid,
                   output ready);
endinterface

interface tcasd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tcasd_pkg::CSR_INDEX_W-1:0] index;
   logic [tcasd_pkg::SAMPLE_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tcasd_mult.sv
// ----------------------------------------------------------------------------
// tcasd_mult - offset and cross-multiply stage
// Removes each channel's midpoint and scales it by the other channel's
// amplitude, keeping the amplitude signs; flags a zero amplitude.
// ----------------------------------------------------------------------------
module tcasd_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  tcasd_pkg::cfg_type    cfg,
   input  logic                  up_valid,
   input  tcasd_pkg::sample_type up_data,
   output logic                  up_ready,
   output logic                  dn_valid,
   output tcasd_pkg::prod_type   dn_data,
   input  logic                  dn_ready
);
   import tcasd_pkg::*;

   logic [SAMPLE_BITS:0]    a_sum, b_sum;
   logic [SAMPLE_BITS-1:0]  a_mid, b_mid;
   logic signed [OFS_W-1:0] a_amp, b_amp, a_abs, b_abs, y_fac, x_fac;
   logic signed [OFS_W-1:0] a_ofs, b_ofs;
   logic                    valid_ff, valid_in;
   prod_type                data_ff, data_in;

   // midpoints and amplitudes from the calibration registers
   always_comb begin
      a_sum = {1'b0, cfg.a_max} + {1'b0, cfg.a_min};
      b_sum = {1'b0, cfg.b_max} + {1'b0, cfg.b_min};
      a_mid = a_sum[SAMPLE_BITS:1];
      b_mid = b_sum[SAMPLE_BITS:1];
      a_amp = $signed({1'b0, cfg.a_max}) - $signed({1'b0, a_mid});
      b_amp = $signed({1'b0, cfg.b_max}) - $signed({1'b0, b_mid});
      a_abs = a_amp[OFS_W-1] ? -a_amp : a_amp;
      b_abs = b_amp[OFS_W-1] ? -b_amp : b_amp;
      // sign of own amplitude times magnitude of the other one
      y_fac = a_amp[OFS_W-1] ? -b_abs : b_abs;
      x_fac = b_amp[OFS_W-1] ? -a_abs : a_abs;
   end

   // cross-multiply the offsets
   always_comb begin
      a_ofs = $signed({1'b0, up_data.a_sample}) - $signed({1'b0, a_mid});
      b_ofs = $signed({1'b0, up_data.b_sample}) - $signed({1'b0, b_mid});
      data_in.y       = a_ofs * y_fac;
      data_in.x       = b_ofs * x_fac;
      data_in.invalid = (a_amp == '0) || (b_amp == '0);
      valid_in        = up_valid;
   end

   // hold the word until the next stage takes it
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: rtl/tcasd_quad.sv
// ----------------------------------------------------------------------------
// tcasd_quad - quadrant reduction stage
// Turns the vector by whole quarter turns into the first quadrant, scales it
// into the CORDIC format and flags the all-zero vector.
// ----------------------------------------------------------------------------
module tcasd_quad (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   input  tcasd_pkg::prod_type up_data,
   output logic                up_ready,
   output logic                dn_valid,
   output tcasd_pkg::vec_type  dn_data,
   input  logic                dn_ready
);
   import tcasd_pkg::*;

   logic signed [PROD_W-1:0] x, y, rx, ry;
   logic signed [VEC_W-1:0]  rx_ext, ry_ext;
   logic [1:0]               q;
   logic                     valid_ff, valid_in;
   vec_type                  data_ff, data_in;

   // pick the quarter turn that lands in x > 0, y >= 0
   always_comb begin
      x = up_data.x;
      y = up_data.y;
      if (x > 0 && y >= 0) begin
         q  = 2'd0;
         rx = x;
         ry = y;
      end else if (y > 0 && x <= 0) begin
         q  = 2'd1;
         rx = y;
         ry = -x;
      end else if (x < 0 && y <= 0) begin
         q  = 2'd2;
         rx = -x;
         ry = -y;
      end else begin
         q  = 2'd3;
         rx = -y;
         ry = x;
      end
      rx_ext = {{(VEC_W-PROD_W){rx[PROD_W-1]}}, rx};
      ry_ext = {{(VEC_W-PROD_W){ry[PROD_W-1]}}, ry};
      data_in.x       = {rx_ext[VEC_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      data_in.y       = {ry_ext[VEC_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      data_in.z       = '0;
      data_in.q       = q;
      data_in.invalid = up_data.invalid || (x == '0 && y == '0);
      valid_in        = up_valid;
   end

   // hold the word until the next stage takes it
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: rtl/tcasd_cordic_cell.sv
// ----------------------------------------------------------------------------
// tcasd_cordic_cell - one vectoring CORDIC micro-rotation
// Rotates toward y = 0 by atan(2^-SHIFT) and tracks the angle; a word whose
// y is already zero passes unchanged.
// ----------------------------------------------------------------------------
module tcasd_cordic_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  tcasd_pkg::vec_type up_data,
   output logic               up_ready,
   output logic               dn_valid,
   output tcasd_pkg::vec_type dn_data,
   input  logic               dn_ready
);
   import tcasd_pkg::*;

   localparam logic signed [TURN_W-1:0] STEP_ANGLE = ATAN_TAB[SHIFT];

   logic signed [VEC_W-1:0] xs, ys;
   logic                    valid_ff, valid_in;
   vec_type                 data_ff, data_in;

   // rotate by the sign of y
   always_comb begin
      xs      = up_data.x >>> SHIFT;
      ys      = up_data.y >>> SHIFT;
      data_in = up_data;
      if (up_data.y > 0) begin
         data_in.x = up_data.x + ys;
         data_in.y = up_data.y - xs;
         data_in.z = up_data.z + STEP_ANGLE;
      end else if (up_data.y < 0) begin
         data_in.x = up_data.x - ys;
         data_in.y = up_data.y + xs;
         data_in.z = up_data.z - STEP_ANGLE;
      end
      valid_in = up_valid;
   end

   // hold the word until the next cell takes it
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: rtl/tcasd_scale.sv
// ----------------------------------------------------------------------------
// tcasd_scale - angle scaling and output register
// Clamps the residual angle to one quarter turn, adds the quarter turns and
// scales the turn fraction to angle steps.
// ----------------------------------------------------------------------------
module tcasd_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  tcasd_pkg::vec_type    up_data,
   output logic                  up_ready,
   output logic                  dn_valid,
   output tcasd_pkg::result_type dn_data,
   input  logic                  dn_ready
);
   import tcasd_pkg::*;

   logic [QUAD_BITS-1:0]       z_clamp;
   logic [TURN_W-1:0]          acc;
   logic [TURN_W+STEPS_W-1:0]  scaled;
   logic                       valid_ff, valid_in;
   result_type                 data_ff, data_in;

   // clamp, combine and scale
   always_comb begin
      if (up_data.z[TURN_W-1]) begin
         z_clamp = '0;
      end else if (up_data.z[TURN_W-2:QUAD_BITS] != '0) begin
         z_clamp = '1;
      end else begin
         z_clamp = up_data.z[QUAD_BITS-1:0];
      end
      acc    = {up_data.q, z_clamp};
      scaled = acc * ANGLE_STEPS;
      data_in.angle   = up_data.invalid ? '0 : scaled[TURN_W +: ANGLE_W];
      data_in.invalid = up_data.invalid;
      valid_in        = up_valid;
   end

   // hold the result until it is taken
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: rtl/two_channel_angle_sensor_decoder_unit.sv
// ----------------------------------------------------------------------------
// two_channel_angle_sensor_decoder_unit - sine/cosine sensor angle decoder
// Turns a pair of ADC samples into a full-circle angle in thousandths of a
// turn through a pipelined chain of vectoring CORDIC cells.
//
//   channel  dir  handshake    payload
//   req_if   in   valid/ready  a_sample[11:0], b_sample[11:0]
//   rsp_if   out  valid/ready  angle_milliturn[9:0], angle_invalid
//   csr_if   in   valid/ready  index[7:0], data[11:0]
//
// One word enters per cycle unless back-pressure holds req_if.ready low; each
// word passes the multiply, quadrant, one cell per CORDIC stage and scaling/output register in order.
// Each stage holds its word while the next one is full, so a stalled
// output fills bubbles before req_if.ready drops.
// Synchronous reset empties the pipeline and loads the default calibration.
// Register writes are always taken (csr_if.ready is high).
// ----------------------------------------------------------------------------
module two_channel_angle_sensor_decoder_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   tcasd_req_if.sink   req_if,
   tcasd_rsp_if.source rsp_if,
   tcasd_csr_if.sink   csr_if
);
   import tcasd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   sample_type req_word;
   logic       mult_valid, mult_ready, quad_ready;
   prod_type   mult_data;
   logic       cell_valid [CORDIC_STAGES+1];
   logic       cell_ready [CORDIC_STAGES+1];
   vec_type    cell_data  [CORDIC_STAGES+1];
   result_type rsp_word;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_A_MAX: cfg_in.a_max = csr_if.data;
            CSR_A_MIN: cfg_in.a_min = csr_if.data;
            CSR_B_MAX: cfg_in.b_max = csr_if.data;
            CSR_B_MIN: cfg_in.b_min = csr_if.data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_max <= RST_CH_MAX;
         cfg_ff.a_min <= RST_CH_MIN;
         cfg_ff.b_max <= RST_CH_MAX;
         cfg_ff.b_min <= RST_CH_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_if.ready = 1'b1;

   assign req_word.a_sample = req_if.a_sample;
   assign req_word.b_sample = req_if.b_sample;

   tcasd_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req_if.valid),
      .up_data  (req_word),
      .up_ready (req_if.ready),
      .dn_valid (mult_valid),
      .dn_data  (mult_data),
      .dn_ready (mult_ready)
   );

   tcasd_quad u_quad (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mult_valid),
      .up_data  (mult_data),
      .up_ready (mult_ready),
      .dn_valid (cell_valid[0]),
      .dn_data  (cell_data[0]),
      .dn_ready (quad_ready)
   );

   assign quad_ready = cell_ready[0];

   // chain of CORDIC cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      tcasd_cordic_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cell_valid[i]),
         .up_data  (cell_data[i]),
         .up_ready (cell_ready[i]),
         .dn_valid (cell_valid[i+1]),
         .dn_data  (cell_data[i+1]),
         .dn_ready (cell_ready[i+1])
      );
   end

   tcasd_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cell_valid[CORDIC_STAGES]),
      .up_data  (cell_data[CORDIC_STAGES]),
      .up_ready (cell_ready[CORDIC_STAGES]),
      .dn_valid (rsp_if.valid),
      .dn_data  (rsp_word),
      .dn_ready (rsp_if.ready)
   );

   assign rsp_if.angle_milliturn = rsp_word.angle;
   assign rsp_if.angle_invalid   = rsp_word.invalid;

`ifndef NO_ASSERTIONS
   // an undefined angle always reads as zero
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.angle_invalid |-> rsp_if.angle_milliturn == '0)
      else $error("invalid result carries a nonzero angle");

   // the angle stays inside one turn
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.angle_milliturn < ANGLE_STEPS)
      else $error("angle out of range");

   // input back-pressure only comes from a stalled output
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready)
      else $error("input stalled without output back-pressure");
`endif

endmodule
